// ===== sv/cqq_pkg.sv =====
package cqq_pkg;

	localparam int VAL_W = 32;
	localparam int TALLY_W = 4;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 4;
	localparam int KIND_W = 3;

	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GREATER = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EVEN    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value_out;
		logic [TALLY_W-1:0]      tally;
		logic [STATUS_W-1:0]     status;
		logic [OCC_W-1:0]        occupancy;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_POP_UPD,
		S_SCAN,
		S_SCAN_END,
		S_REV_RDA,
		S_REV_RDB,
		S_REV_WRA,
		S_REV_WRB,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    push_wr;
		logic    pop_rd;
		logic    pop_upd;
		logic    set_status;
		status_t status_code;
		logic    scan_rd;
		logic    scan_acc;
		logic    rev_rda;
		logic    rev_rdb;
		logic    rev_wra;
		logic    rev_wrb;
		logic    emit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              empty;
		logic              full;
		logic              multi;
		logic              scan_last;
		logic              rev_more;
		logic              out_free;
	} stat_t;

endpackage

// ===== sv/cqq_ram.sv =====
module cqq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cqq_ctrl.sv =====
module cqq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  cqq_pkg::stat_t   stat,
	output cqq_pkg::cmd_t    cmd,
	output cqq_pkg::state_t  state
);

	cqq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cqq_pkg::S_IDLE: begin
				if (req_valid) state_d = cqq_pkg::S_EXEC;
			end
			cqq_pkg::S_EXEC: begin
				unique case (stat.kind)
					cqq_pkg::KIND_POP: begin
						state_d = stat.empty ? cqq_pkg::S_DONE : cqq_pkg::S_POP_UPD;
					end
					cqq_pkg::KIND_GREATER, cqq_pkg::KIND_EVEN: begin
						state_d = stat.empty ? cqq_pkg::S_DONE : cqq_pkg::S_SCAN;
					end
					cqq_pkg::KIND_REVERSE: begin
						state_d = stat.multi ? cqq_pkg::S_REV_RDA : cqq_pkg::S_DONE;
					end
					default: begin
						state_d = cqq_pkg::S_DONE;
					end
				endcase
			end
			cqq_pkg::S_POP_UPD:  state_d = cqq_pkg::S_DONE;
			cqq_pkg::S_SCAN: begin
				if (stat.scan_last) state_d = cqq_pkg::S_SCAN_END;
			end
			cqq_pkg::S_SCAN_END: state_d = cqq_pkg::S_DONE;
			cqq_pkg::S_REV_RDA:  state_d = cqq_pkg::S_REV_RDB;
			cqq_pkg::S_REV_RDB:  state_d = cqq_pkg::S_REV_WRA;
			cqq_pkg::S_REV_WRA:  state_d = cqq_pkg::S_REV_WRB;
			cqq_pkg::S_REV_WRB: begin
				state_d = stat.rev_more ? cqq_pkg::S_REV_RDA : cqq_pkg::S_DONE;
			end
			cqq_pkg::S_DONE: begin
				if (stat.out_free) state_d = cqq_pkg::S_IDLE;
			end
			default: state_d = cqq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status_code = cqq_pkg::STATUS_OK;
		req_ready = 1'b0;
		unique case (state_q)
			cqq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			cqq_pkg::S_EXEC: begin
				unique case (stat.kind)
					cqq_pkg::KIND_PUSH: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status_code = cqq_pkg::STATUS_FULL;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					cqq_pkg::KIND_POP: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status_code = cqq_pkg::STATUS_EMPTY;
						end else begin
							cmd.pop_rd = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			cqq_pkg::S_POP_UPD: cmd.pop_upd = 1'b1;
			cqq_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.scan_acc = 1'b1;
			end
			cqq_pkg::S_SCAN_END: cmd.scan_acc = 1'b1;
			cqq_pkg::S_REV_RDA:  cmd.rev_rda = 1'b1;
			cqq_pkg::S_REV_RDB:  cmd.rev_rdb = 1'b1;
			cqq_pkg::S_REV_WRA:  cmd.rev_wra = 1'b1;
			cqq_pkg::S_REV_WRB:  cmd.rev_wrb = 1'b1;
			cqq_pkg::S_DONE:     cmd.emit = stat.out_free;
			default: begin
			end
		endcase
	end

	assign state = state_q;

endmodule

// ===== sv/cqq_dp.sv =====
module cqq_dp #(
	parameter int DEPTH = 8,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cqq_pkg::req_t  req,
	input  cqq_pkg::cmd_t  cmd,
	output cqq_pkg::stat_t stat,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cqq_pkg::rsp_t  rsp
);

	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0]                 head_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             pend_q;
	logic                             rsp_valid_q;
	logic [cqq_pkg::KIND_W-1:0]       kind_q;
	logic signed [cqq_pkg::VAL_W-1:0] val_q;
	logic [CNT_W-1:0]                 lo_q, hi_q, tally_q;
	logic [cqq_pkg::VAL_W-1:0]        tmp_q, vout_q;
	cqq_pkg::status_t                 status_q;
	cqq_pkg::rsp_t                    rsp_q;

	logic                             we;
	logic [IDX_W-1:0]                 waddr, raddr;
	logic [cqq_pkg::VAL_W-1:0]        wdata, rdata;
	logic                             hit;

	// Store position of the entry pos places after the head; the sum stays
	// below twice the depth, so one subtraction wraps it.
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
	                                          input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] s;
		s = SUM_W'(head) + SUM_W'(pos);
		if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	cqq_ram #(
		.WIDTH(cqq_pkg::VAL_W),
		.DEPTH(DEPTH),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		we = cmd.push_wr | cmd.rev_wra | cmd.rev_wrb;
		waddr = slot(head_q, count_q);
		wdata = val_q;
		if (cmd.rev_wra) begin
			waddr = slot(head_q, lo_q);
			wdata = rdata;
		end else if (cmd.rev_wrb) begin
			waddr = slot(head_q, hi_q);
			wdata = tmp_q;
		end
	end

	always_comb begin
		raddr = '0;
		if (cmd.pop_rd) begin
			raddr = head_q;
		end else if (cmd.scan_rd || cmd.rev_rda) begin
			raddr = slot(head_q, lo_q);
		end else if (cmd.rev_rdb) begin
			raddr = slot(head_q, hi_q);
		end
	end

	always_comb begin
		if (kind_q == cqq_pkg::KIND_GREATER) begin
			hit = $signed(rdata) > val_q;
		end else begin
			hit = ~rdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.scan_rd;
			if (cmd.push_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop_upd) begin
				count_q <= count_q - CNT_W'(1);
				head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			val_q <= req.value_in;
			lo_q <= '0;
			hi_q <= count_q - CNT_W'(1);
			tally_q <= '0;
			vout_q <= '0;
			status_q <= cqq_pkg::STATUS_OK;
		end
		if (cmd.set_status) status_q <= cmd.status_code;
		if (cmd.pop_upd) vout_q <= rdata;
		if (cmd.scan_rd) lo_q <= lo_q + CNT_W'(1);
		if (cmd.scan_acc && pend_q && hit) tally_q <= tally_q + CNT_W'(1);
		if (cmd.rev_rdb) tmp_q <= rdata;
		if (cmd.rev_wrb) begin
			lo_q <= lo_q + CNT_W'(1);
			hi_q <= hi_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			rsp_q.value_out <= vout_q;
			rsp_q.tally <= cqq_pkg::TALLY_W'(tally_q);
			rsp_q.status <= status_q;
			rsp_q.occupancy <= cqq_pkg::OCC_W'(count_q);
		end
	end

	assign stat.kind = kind_q;
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.multi = (count_q > CNT_W'(1));
	assign stat.scan_last = ((SUM_W'(lo_q) + SUM_W'(1)) == SUM_W'(count_q));
	assign stat.rev_more = ((SUM_W'(lo_q) + SUM_W'(2)) < SUM_W'(hi_q));
	assign stat.out_free = ~rsp_valid_q | rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== sv/circular_queue_with_queries.sv =====
// Channel  Handshake             Payload           Direction
// req      req_valid/req_ready   cqq_pkg::req_t    in   (kind, value_in)
// rsp      rsp_valid/rsp_ready   cqq_pkg::rsp_t    out  (value_out, tally, status, occupancy)
//
// One item is worked on at a time; the entry store has a single read port with
// registered data, which sets the length of each operation. Push and unused
// kinds go straight to the result; pop reads the head, then updates it; count
// operations read each entry in turn (none on an empty queue); reverse reads
// both ends, then writes both, per swapped pair. A new item is taken while a
// result still waits, and the block stalls before writing a second result.
// Reset clears head, count and the handshakes; the store is not cleared.
module circular_queue_with_queries #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cqq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cqq_pkg::rsp_t rsp
);

	cqq_pkg::cmd_t   cmd;
	cqq_pkg::stat_t  stat;
	cqq_pkg::state_t state;

	cqq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	cqq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// A push never writes into a full queue, nor a pop drains an empty one.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !stat.full)
		else $error("push written into a full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_upd |-> !stat.empty)
		else $error("pop taken from an empty queue");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (!req_ready && state == cqq_pkg::S_EXEC))
		else $error("second item accepted while one is in work");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp_valid)
		else $error("result written but not presented");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == cqq_pkg::STATUS_FULL ||
		               rsp.status == cqq_pkg::STATUS_EMPTY))
		|-> (rsp.value_out == '0 && rsp.tally == '0))
		else $error("refused operation returned data");

endmodule

// ===== test/circular_queue_with_queries_test.sv =====
module circular_queue_with_queries_test;

	import cqq_pkg::*;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	// Kinds that the block treats as no operation.
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	localparam logic signed [VAL_W-1:0] WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] WORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// While set, neither side inserts any idle cycles.
	bit steady = 1'b0;

	class queue_mirror;
		logic signed [VAL_W-1:0] store [QUEUE_DEPTH];
		logic [IDX_W-1:0] head;
		int unsigned count;
		rsp_t pending_results [$];
		int mismatches;

		function new();
			head = '0;
			count = 0;
			mismatches = 0;
		endfunction

		// Store position of the entry that lies pos places after the head.
		function logic [IDX_W-1:0] slot(int unsigned pos);
			return head + IDX_W'(pos);
		endfunction

		function void note_request(req_t item);
			rsp_t want;
			int unsigned lo;
			int unsigned hi;
			logic signed [VAL_W-1:0] held;
			want = '0;
			case (item.kind)
			KIND_PUSH: begin
				if (count >= QUEUE_DEPTH) begin
					want.status = STATUS_FULL;
				end else begin
					store[slot(count)] = item.value_in;
					count++;
				end
			end
			KIND_POP: begin
				if (count == 0) begin
					want.status = STATUS_EMPTY;
				end else begin
					want.value_out = store[head];
					head = head + 1'b1;
					count--;
				end
			end
			KIND_GREATER: begin
				for (int unsigned i = 0; i < count; i++)
					if (store[slot(i)] > item.value_in)
						want.tally++;
			end
			KIND_EVEN: begin
				for (int unsigned i = 0; i < count; i++)
					if (!store[slot(i)][0])
						want.tally++;
			end
			KIND_REVERSE: begin
				if (count > 1) begin
					lo = 0;
					hi = count - 1;
					while (lo < hi) begin
						held = store[slot(lo)];
						store[slot(lo)] = store[slot(hi)];
						store[slot(hi)] = held;
						lo++;
						hi--;
					end
				end
			end
			default: begin
			end
			endcase
			want.occupancy = OCC_W'(count);
			pending_results.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: value_out %0d tally %0d",
						got.value_out, got.tally);
					$display("  status %0d occupancy %0d", got.status, got.occupancy);
				end
				return;
			end
			want = pending_results.pop_front();
			if (got.value_out !== want.value_out || got.tally !== want.tally ||
					got.status !== want.status || got.occupancy !== want.occupancy) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch (expected/actual): value_out %0d/%0d tally %0d/%0d",
						want.value_out, got.value_out, want.tally, got.tally);
					$display("  status %0d/%0d occupancy %0d/%0d",
						want.status, got.status, want.occupancy, got.occupancy);
				end
			end
		endfunction
	endclass

	queue_mirror mirror;

	circular_queue_with_queries #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// Results are checked before the new item is noted, so that a result can
	// never be matched against an item accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				mirror.check_response(rsp);
			if (req_valid && req_ready)
				mirror.note_request(req);
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [VAL_W-1:0] word);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind: kind, value_in: word};
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return WORD_MIN;
		1: return WORD_MAX;
		2, 3: return int'($urandom_range(0, 8)) - 4;
		default: return $urandom;
		endcase
	endfunction

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		#2_000_000;
		$display("[circular_queue_with_queries] ERROR");
		$finish;
	end

	initial begin
		int pick;
		int push_weight;
		logic [KIND_W-1:0] op_kind;
		mirror = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Operations on an empty queue, then fill it past full with the extremes.
		send_item(KIND_POP, '0);
		send_item(KIND_GREATER, '0);
		send_item(KIND_EVEN, '0);
		send_item(KIND_REVERSE, '0);
		send_item(KIND_SPARE_LO, WORD_MAX);
		send_item(KIND_SPARE_HI, WORD_MIN);
		send_item(KIND_PUSH, WORD_MAX);
		send_item(KIND_REVERSE, '0);
		send_item(KIND_PUSH, WORD_MIN);
		send_item(KIND_PUSH, '0);
		send_item(KIND_PUSH, -1);
		send_item(KIND_PUSH, 2);
		send_item(KIND_PUSH, 1);
		send_item(KIND_PUSH, WORD_MAX - 1);
		send_item(KIND_PUSH, WORD_MIN + 1);
		send_item(KIND_PUSH, 5);
		send_item(KIND_GREATER, WORD_MIN);
		send_item(KIND_GREATER, WORD_MAX);
		send_item(KIND_GREATER, -1);
		send_item(KIND_EVEN, '0);
		send_item(KIND_REVERSE, '0);
		send_item(KIND_POP, '0);
		send_item(KIND_REVERSE, '0);
		send_item(KIND_POP, '0);

		// Each phase leans towards pushing or popping so that the occupancy
		// wanders between empty and full and the head wraps round.
		for (int phase = 0; phase < 15; phase++) begin
			steady = (phase % 4 == 1);
			push_weight = $urandom_range(25, 60);
			repeat (50) begin
				pick = $urandom_range(0, 99);
				if (pick < push_weight)
					op_kind = KIND_PUSH;
				else if (pick < 70)
					op_kind = KIND_POP;
				else if (pick < 80)
					op_kind = KIND_GREATER;
				else if (pick < 88)
					op_kind = KIND_EVEN;
				else if (pick < 96)
					op_kind = KIND_REVERSE;
				else
					op_kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
				send_item(op_kind, pick_word());
			end
		end
		steady = 1'b0;
		req_valid <= 1'b0;

		while (mirror.pending_results.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("[circular_queue_with_queries] OK");
		else
			$display("[circular_queue_with_queries] ERROR");
		$finish;
	end

endmodule
